// File: hw/rtl/ubx_fe_pkg.sv
package ubx_fe_pkg;

  // one message as it arrives
  typedef struct packed {
    logic        [7:0]  msg_class;
    logic        [7:0]  msg_id;
    logic signed [15:0] word0;
    logic signed [15:0] word1;
    logic signed [15:0] word2;
    logic signed [15:0] word3;
    logic signed [15:0] word4;
    logic signed [15:0] word5;
  } in_t;

  // one frame byte as it leaves
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_t;

  localparam int unsigned BODY_LEN = 18;
  localparam int unsigned CNT_W    = 5;

  localparam logic [7:0]       SYNC_FIRST  = 8'hB5;
  localparam logic [7:0]       SYNC_SECOND = 8'h62;
  localparam logic [15:0]      PAYLOAD_LEN = 16'd12;

  // byte positions inside the frame
  localparam logic [CNT_W-1:0] SUM_FIRST_IDX = 5'd2;
  localparam logic [CNT_W-1:0] SUM_LAST_IDX  = 5'd17;
  localparam logic [CNT_W-1:0] CK_A_IDX      = 5'd18;
  localparam logic [CNT_W-1:0] CK_B_IDX      = 5'd19;

endpackage

// File: hw/rtl/ubx_fe_msg_queue.sv
module ubx_fe_msg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  input  ubx_fe_pkg::in_t wr_data,
  output logic            full,
  output logic            rd_valid,
  output ubx_fe_pkg::in_t rd_data,
  input  logic            rd_pop
);

  ubx_fe_pkg::in_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r,  count_nxt;
  logic            push, pop;

  assign full     = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];

  assign push = wr_valid && !full;
  assign pop  = rd_pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: hw/rtl/ubx_fe_serializer.sv
module ubx_fe_serializer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             msg_valid,
  input  ubx_fe_pkg::in_t  msg_data,
  output logic             msg_pop,
  output logic             out_valid,
  output ubx_fe_pkg::out_t out_data,
  input  logic             out_stall
);

  logic [ubx_fe_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]                   sum_a_r, sum_a_nxt;
  logic [7:0]                   sum_b_r, sum_b_nxt;
  logic                         out_valid_r, out_valid_nxt;
  ubx_fe_pkg::out_t             out_data_r, out_data_nxt;
  logic [7:0]                   body [ubx_fe_pkg::BODY_LEN];
  logic [7:0]                   cur_byte;
  logic                         advance;
  logic                         in_sum;
  logic                         at_end;

  // header and payload bytes of the frame at the queue head
  always_comb begin
    body[0]  = ubx_fe_pkg::SYNC_FIRST;
    body[1]  = ubx_fe_pkg::SYNC_SECOND;
    body[2]  = msg_data.msg_class;
    body[3]  = msg_data.msg_id;
    body[4]  = ubx_fe_pkg::PAYLOAD_LEN[7:0];
    body[5]  = ubx_fe_pkg::PAYLOAD_LEN[15:8];
    body[6]  = msg_data.word0[7:0];
    body[7]  = msg_data.word0[15:8];
    body[8]  = msg_data.word1[7:0];
    body[9]  = msg_data.word1[15:8];
    body[10] = msg_data.word2[7:0];
    body[11] = msg_data.word2[15:8];
    body[12] = msg_data.word3[7:0];
    body[13] = msg_data.word3[15:8];
    body[14] = msg_data.word4[7:0];
    body[15] = msg_data.word4[15:8];
    body[16] = msg_data.word5[7:0];
    body[17] = msg_data.word5[15:8];
  end

  assign advance = msg_valid && (!out_valid_r || !out_stall);
  assign at_end  = (cnt_r == ubx_fe_pkg::CK_B_IDX);
  assign in_sum  = (cnt_r >= ubx_fe_pkg::SUM_FIRST_IDX) &&
                   (cnt_r <= ubx_fe_pkg::SUM_LAST_IDX);
  assign msg_pop = advance && at_end;

  always_comb begin
    if (cnt_r == ubx_fe_pkg::CK_A_IDX) begin
      cur_byte = sum_a_r;
    end else if (at_end) begin
      cur_byte = sum_b_r;
    end else begin
      cur_byte = body[cnt_r];
    end
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    sum_a_nxt     = sum_a_r;
    sum_b_nxt     = sum_b_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (advance) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.frame_byte = cur_byte;
      out_data_nxt.last_byte  = at_end;
      if (at_end) begin
        cnt_nxt   = '0;
        sum_a_nxt = 8'd0;
        sum_b_nxt = 8'd0;
      end else begin
        cnt_nxt = cnt_r + 5'd1;
        if (in_sum) begin
          sum_a_nxt = sum_a_r + cur_byte;
          sum_b_nxt = sum_b_r + sum_a_r + cur_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sum_a_r     <= 8'd0;
      sum_b_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      sum_a_r     <= sum_a_nxt;
      sum_b_r     <= sum_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // byte counter never runs past the second checksum
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ubx_fe_pkg::CK_B_IDX)
    else $error("byte counter out of range");

  // a frame in progress keeps its message at the queue head
  a_msg_held: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 |-> msg_valid)
    else $error("message lost mid frame");

  // the flagged byte closes the frame and rewinds the counter
  a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last_byte |-> cnt_r == '0 && sum_a_r == 8'd0)
    else $error("last byte without counter rewind");

  // sums are clear whenever a frame starts
  a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ubx_fe_pkg::SUM_FIRST_IDX |-> sum_a_r == 8'd0 && sum_b_r == 8'd0)
    else $error("checksum not cleared at frame start");

endmodule

// File: hw/rtl/ubx_frame_encoder.sv
// the message beat is first written into the queue, then its first frame byte is registered onto out_data
// throughput: one frame byte per cycle while out_stall is low and a message is queued, with
//   the twenty bytes each frame takes on the one-byte output
// the two-entry message queue takes a new message while a frame is going out
// reset (rst_n low, synchronous) empties the queue and rewinds the byte counter
module ubx_frame_encoder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  ubx_fe_pkg::in_t  in_data,
  output logic             in_stall,
  output logic             out_valid,
  output ubx_fe_pkg::out_t out_data,
  input  logic             out_stall
);

  // front: message beats land in a short queue
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  ubx_fe_pkg::in_t q_data;

  // input side stalls only when both queue entries are taken
  assign in_stall = q_full;

  ubx_fe_msg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_data  (in_data),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_data  (q_data),
    .rd_pop   (q_pop)
  );

  // back: walks the 20 frame bytes of the head message, folding the
  // fletcher sums as class through payload go by, pops at the last byte
  ubx_fe_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_valid (q_valid),
    .msg_data  (q_data),
    .msg_pop   (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

// File: verif/tb_ubx_frame_encoder.sv
module tb_ubx_frame_encoder;

  // frame layout constants, kept local so the check does not lean on the rtl package
  localparam logic [7:0] HDR_SYNC_A  = 8'hB5;
  localparam logic [7:0] HDR_SYNC_B  = 8'h62;
  localparam logic [7:0] HDR_LEN_LO  = 8'h0C;
  localparam logic [7:0] HDR_LEN_HI  = 8'h00;
  localparam int         FRAME_BYTES = 20;
  localparam int         WORDS       = 6;

  // cycles without any beat on either side before the run is declared hung
  localparam int QUIET_LIMIT = 4000;
  // settle time after the last expected byte
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  ubx_fe_pkg::in_t  in_data;
  logic             in_stall;
  logic             out_valid;
  ubx_fe_pkg::out_t out_data;
  logic             out_stall;

  // frame bytes still owed by the block, oldest first
  ubx_fe_pkg::out_t pending_bytes[$];

  int src_idle_pct;
  int sink_stall_pct;
  int mismatches;
  int quiet_cycles;

  ubx_frame_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // frame predictor: header, little-endian payload, fletcher-8 over class..payload
  // ---------------------------------------------------------------------------
  function automatic void queue_frame(input ubx_fe_pkg::in_t msg);
    logic [7:0]       frame [FRAME_BYTES];
    logic [15:0]      words [WORDS];
    logic [7:0]       ck_a;
    logic [7:0]       ck_b;
    ubx_fe_pkg::out_t beat;
    words[0] = msg.word0;
    words[1] = msg.word1;
    words[2] = msg.word2;
    words[3] = msg.word3;
    words[4] = msg.word4;
    words[5] = msg.word5;
    frame[0] = HDR_SYNC_A;
    frame[1] = HDR_SYNC_B;
    frame[2] = msg.msg_class;
    frame[3] = msg.msg_id;
    frame[4] = HDR_LEN_LO;
    frame[5] = HDR_LEN_HI;
    // negative words go out as their raw two's complement bits, low byte first
    for (int k = 0; k < WORDS; k++) begin
      frame[6 + 2 * k] = words[k][7:0];
      frame[7 + 2 * k] = words[k][15:8];
    end
    // both sums wrap at 8 bits, sync bytes excluded, length bytes included
    ck_a = 8'h00;
    ck_b = 8'h00;
    for (int k = 2; k < FRAME_BYTES - 2; k++) begin
      ck_a = ck_a + frame[k];
      ck_b = ck_b + ck_a;
    end
    frame[FRAME_BYTES - 2] = ck_a;
    frame[FRAME_BYTES - 1] = ck_b;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      beat.frame_byte = frame[k];
      beat.last_byte  = (k == FRAME_BYTES - 1);
      pending_bytes.push_back(beat);
    end
  endfunction

  function automatic ubx_fe_pkg::in_t make_msg(input logic [7:0] cls, input logic [7:0] id,
                                               input logic [15:0] w0, input logic [15:0] w1,
                                               input logic [15:0] w2, input logic [15:0] w3,
                                               input logic [15:0] w4, input logic [15:0] w5);
    ubx_fe_pkg::in_t msg;
    msg.msg_class = cls;
    msg.msg_id    = id;
    msg.word0     = w0;
    msg.word1     = w1;
    msg.word2     = w2;
    msg.word3     = w3;
    msg.word4     = w4;
    msg.word5     = w5;
    return msg;
  endfunction

  // payload words lean toward the signed extremes, minus one and zero, the rest uniform
  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic ubx_fe_pkg::in_t random_msg();
    return make_msg(8'($urandom_range(255)), 8'($urandom_range(255)),
                    pick_word(), pick_word(), pick_word(), pick_word(),
                    pick_word(), pick_word());
  endfunction

  // ---------------------------------------------------------------------------
  // sender: called in step with the clock, returns once the block has taken the beat
  // valid is only driven once per step so back-to-back beats keep it high
  // ---------------------------------------------------------------------------
  task automatic send_msg(input ubx_fe_pkg::in_t msg);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= msg;
    // the frame cannot start before the beat is taken, so queue it now
    queue_frame(msg);
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  // drop valid and hold off until every owed byte has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_bytes.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall, and the byte check on every accepted beat
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input int exp_val, input int got_val);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch in %s: expected %0h, got %0h", what, exp_val, got_val);
  endtask

  always @(posedge clk) begin
    ubx_fe_pkg::out_t want;
    out_stall <= ($urandom_range(99) < sink_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        note_mismatch("unexpected frame byte", 0, out_data.frame_byte);
      end else begin
        want = pending_bytes.pop_front();
        if (out_data.frame_byte !== want.frame_byte)
          note_mismatch("frame_byte", want.frame_byte, out_data.frame_byte);
        if (out_data.last_byte !== want.last_byte)
          note_mismatch("last_byte", want.last_byte, out_data.last_byte);
      end
    end
  end

  // watchdog on stretches with no beat in either direction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, sign patterns and checksum wrap, sent back to back
  task automatic test_directed_frames();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_msg(make_msg(8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                      16'h0000, 16'h0000, 16'h0000));
    send_msg(make_msg(8'hFF, 8'hFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                      16'h7FFF, 16'h7FFF, 16'h7FFF));
    // most negative words
    send_msg(make_msg(8'h01, 8'h02, 16'h8000, 16'h8000, 16'h8000,
                      16'h8000, 16'h8000, 16'h8000));
    // all ones payload, both sums wrap many times
    send_msg(make_msg(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF, 16'hFFFF));
    // mixed signs, byte order visible in each word
    send_msg(make_msg(8'h06, 8'h01, 16'h1234, 16'hFEDC, 16'h8001,
                      16'h7FFE, 16'h00FF, 16'hFF00));
    send_msg(make_msg(8'h80, 8'h7F, 16'hAAAA, 16'h5555, 16'hAAAA,
                      16'h5555, 16'hAAAA, 16'h5555));
    send_msg(make_msg(8'h55, 8'hAA, 16'h5555, 16'hAAAA, 16'h5555,
                      16'hAAAA, 16'h5555, 16'hAAAA));
    // walking ones through class, id and the first five words, a walking zero through the last
    for (int b = 0; b < 8; b++)
      send_msg(make_msg(8'h01 << b, 8'h80 >> b, 16'h0001 << b, 16'h0100 << b,
                        16'h0001 << (b + 8), 16'h8000 >> b, 16'h0080 >> b,
                        16'hFFFF ^ (16'h0001 << b)));
  endtask

  task automatic test_random_frames(input int count, input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (int i = 0; i < count; i++)
      send_msg(random_msg());
  endtask

  // let the pipeline run completely dry, then resume with a back-to-back burst
  task automatic test_drain_pause();
    src_idle_pct   = 27;
    sink_stall_pct = 27;
    for (int i = 0; i < 3; i++)
      send_msg(random_msg());
    wait_drained();
    src_idle_pct = 0;
    for (int i = 0; i < 3; i++)
      send_msg(random_msg());
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    rst_n          = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_random_frames(20, 0, 0);
    test_random_frames(20, 73, 0);
    test_random_frames(20, 0, 73);
    test_random_frames(20, 27, 27);
    test_drain_pause();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
